### rtl/fts_pkg.sv
package fts_pkg;

	localparam int unsigned HEADER_BYTES = 6;
	localparam logic [15:0] HEADER_LEN = 16'(HEADER_BYTES);

	localparam logic [10:0] SEG_MAX = 11'd1024;
	localparam logic [23:0] FILE_LIMIT_RESET = 24'd1048576;
	localparam logic [10:0] SEGMENT_SIZE_RESET = 11'd128;

	localparam logic CFG_FILE_LIMIT = 1'b0;
	localparam logic CFG_SEGMENT_SIZE = 1'b1;

	localparam logic [7:0] OP_READ_REQ = 8'd1;
	localparam logic [7:0] OP_WRITE_REQ = 8'd2;
	localparam logic [7:0] OP_DATA = 8'd3;
	localparam logic [7:0] OP_ACK = 8'd4;
	localparam logic [7:0] OP_ERROR = 8'd5;
	localparam logic [7:0] OP_BUSY = 8'd6;

	localparam logic [1:0] RK_NONE = 2'd0;
	localparam logic [1:0] RK_DATA = 2'd1;
	localparam logic [1:0] RK_ACK = 2'd2;
	localparam logic [1:0] RK_ERROR = 2'd3;

	localparam logic [2:0] E_NONE = 3'd0;
	localparam logic [2:0] E_ILLEGAL = 3'd1;
	localparam logic [2:0] E_NOT_FOUND = 3'd2;
	localparam logic [2:0] E_PACKETNO = 3'd3;
	localparam logic [2:0] E_DISKFULL = 3'd4;
	localparam logic [2:0] E_UNDEF = 3'd5;
	localparam logic [2:0] E_PROG = 3'd6;
	localparam logic [2:0] E_SHORT = 3'd7;

	typedef enum logic [1:0] {
		ST_READY = 2'd0,
		ST_WAIT_ACK = 2'd1,
		ST_WAIT_FINAL = 2'd2,
		ST_WAIT_DATA = 2'd3
	} proto_state_t;

	typedef enum logic [2:0] {
		CMD_SHORT = 3'd0,
		CMD_READ = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_DATA = 3'd3,
		CMD_ACK = 3'd4,
		CMD_CANCEL = 3'd5,
		CMD_BUSY = 3'd6,
		CMD_UNDEF = 3'd7
	} cmd_class_t;

	typedef struct packed {
		logic [7:0] opcode;
		logic [15:0] mbx_length;
		logic [31:0] packet_number;
		logic outbox_free;
	} in_item_t;

	typedef struct packed {
		logic [1:0] reply_kind;
		logic [31:0] reply_packet;
		logic [15:0] reply_length;
		logic [2:0] error_kind;
		logic [23:0] move_offset;
		logic [10:0] move_count;
		logic move_is_write;
		logic flush_request;
		logic [1:0] state_after;
	} out_item_t;

	typedef struct packed {
		cmd_class_t cls;
		logic [15:0] dlen;
		logic [31:0] packet_number;
		logic outbox_free;
	} cmd_t;

endpackage

### rtl/foe_file_transfer_slave_unit.sv
// Slave side of the mailbox file-transfer protocol. Each input word is one received
// mailbox header and yields exactly one result word: the reply to send, the file range
// to read or write, a flush request and the protocol state afterwards. The block takes
// one word per cycle while the queue is not full; each word is queued and its result is
// registered. The executor sets the rate, finishing one queued command per cycle while the
// output is not stalled, and a two-word queue between the classifier and the executor plus
// the output register let the input keep flowing while a result waits to be taken.
// Configuration writes are always accepted and are meant to be made while the block is idle.
module foe_file_transfer_slave_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input fts_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output fts_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [23:0] cfg_data
);

	fts_pkg::cmd_t front_cmd;
	fts_pkg::cmd_t head_cmd;
	logic queue_full;
	logic queue_not_empty;
	logic cmd_pop;
	logic push;

	assign cfg_ready = 1'b1;
	assign in_ready = !queue_full;
	assign push = in_valid && !queue_full;

	fts_front u_front (
		.item(in_data),
		.cmd(front_cmd)
	);

	fts_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(front_cmd),
		.full(queue_full),
		.pop(cmd_pop),
		.not_empty(queue_not_empty),
		.head(head_cmd)
	);

	fts_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(queue_not_empty),
		.cmd(head_cmd),
		.cmd_pop(cmd_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

### rtl/fts_front.sv
module fts_front (
	input fts_pkg::in_item_t item,
	output fts_pkg::cmd_t cmd
);

	always_comb begin
		cmd.dlen = item.mbx_length - fts_pkg::HEADER_LEN;
		cmd.packet_number = item.packet_number;
		cmd.outbox_free = item.outbox_free;
		if (item.mbx_length < fts_pkg::HEADER_LEN) begin
			cmd.cls = fts_pkg::CMD_SHORT;
		end else begin
			case (item.opcode)
				fts_pkg::OP_READ_REQ: cmd.cls = fts_pkg::CMD_READ;
				fts_pkg::OP_WRITE_REQ: cmd.cls = fts_pkg::CMD_WRITE;
				fts_pkg::OP_DATA: cmd.cls = fts_pkg::CMD_DATA;
				fts_pkg::OP_ACK: cmd.cls = fts_pkg::CMD_ACK;
				fts_pkg::OP_ERROR: cmd.cls = fts_pkg::CMD_CANCEL;
				fts_pkg::OP_BUSY: cmd.cls = fts_pkg::CMD_BUSY;
				default: cmd.cls = fts_pkg::CMD_UNDEF;
			endcase
		end
	end

endmodule

### rtl/fts_queue.sv
module fts_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input fts_pkg::cmd_t push_data,
	output logic full,
	input logic pop,
	output logic not_empty,
	output fts_pkg::cmd_t head
);

	fts_pkg::cmd_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### rtl/fts_back.sv
module fts_back (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_index,
	input logic [23:0] cfg_data,
	input logic cmd_valid,
	input fts_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic out_valid,
	input logic out_ready,
	output fts_pkg::out_item_t out_data
);

	logic [23:0] lim_q;
	logic [10:0] seg_q;
	fts_pkg::proto_state_t state_q, state_d;
	logic [31:0] pc_q, pc_d;
	logic [23:0] fp_q, fp_d;
	logic [23:0] prev_q, prev_d;

	logic out_valid_q;
	fts_pkg::out_item_t out_data_q;
	fts_pkg::out_item_t res;

	logic [10:0] seg_eff;
	logic [23:0] base_fp;
	logic [31:0] base_pc;
	logic [23:0] rem;
	logic [10:0] snd_cnt;
	logic snd_short;
	logic [23:0] snd_fp;
	logic [24:0] data_sum;
	logic data_full;
	logic data_big;
	logic data_short;
	logic pkt_ok;
	logic free;

	assign free = cmd.outbox_free;
	assign cmd_pop = cmd_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		if (seg_q == 11'd0) begin
			seg_eff = 11'd1;
		end else if (seg_q > fts_pkg::SEG_MAX) begin
			seg_eff = fts_pkg::SEG_MAX;
		end else begin
			seg_eff = seg_q;
		end
	end

	always_comb begin
		case (cmd.cls)
			fts_pkg::CMD_READ: begin
				base_fp = '0;
				base_pc = 32'd1;
			end
			fts_pkg::CMD_BUSY: begin
				base_fp = prev_q;
				base_pc = pc_q - 32'd1;
			end
			default: begin
				base_fp = fp_q;
				base_pc = pc_q;
			end
		endcase
	end

	assign rem = (lim_q > base_fp) ? (lim_q - base_fp) : '0;
	assign snd_cnt = (rem < 24'(seg_eff)) ? rem[10:0] : seg_eff;
	assign snd_short = (snd_cnt < seg_eff);
	assign snd_fp = base_fp + 24'(snd_cnt);

	assign data_sum = 25'(fp_q) + 25'(cmd.dlen);
	assign data_full = (data_sum > 25'(lim_q));
	assign data_big = (cmd.dlen > 16'(seg_eff));
	assign data_short = (cmd.dlen != 16'(seg_eff));
	assign pkt_ok = (cmd.packet_number == pc_q);

	// Next protocol state, packet counter and file positions.
	always_comb begin
		logic idle;
		logic send;
		idle = 1'b0;
		send = 1'b0;
		state_d = state_q;
		pc_d = pc_q;
		fp_d = fp_q;
		prev_d = prev_q;
		case (cmd.cls)
			fts_pkg::CMD_READ: begin
				if (state_q != fts_pkg::ST_READY || !free) begin
					idle = 1'b1;
				end else begin
					send = 1'b1;
				end
			end
			fts_pkg::CMD_WRITE: begin
				if (state_q != fts_pkg::ST_READY || !free) begin
					idle = 1'b1;
				end else begin
					state_d = fts_pkg::ST_WAIT_DATA;
					pc_d = 32'd1;
					fp_d = '0;
					prev_d = '0;
				end
			end
			fts_pkg::CMD_DATA: begin
				if (state_q != fts_pkg::ST_WAIT_DATA || !pkt_ok || data_full || data_big
						|| data_short || !free) begin
					idle = 1'b1;
				end else begin
					prev_d = fp_q;
					fp_d = data_sum[23:0];
					pc_d = pc_q + 32'd1;
				end
			end
			fts_pkg::CMD_ACK, fts_pkg::CMD_BUSY: begin
				if (state_q != fts_pkg::ST_WAIT_ACK || !free) begin
					idle = 1'b1;
				end else begin
					send = 1'b1;
				end
			end
			default: begin
				idle = 1'b1;
			end
		endcase
		if (send) begin
			prev_d = base_fp;
			fp_d = snd_fp;
			pc_d = base_pc + 32'd1;
			if (cmd.cls != fts_pkg::CMD_READ && snd_short) begin
				state_d = fts_pkg::ST_WAIT_FINAL;
			end else begin
				state_d = fts_pkg::ST_WAIT_ACK;
			end
		end
		if (idle) begin
			state_d = fts_pkg::ST_READY;
			pc_d = '0;
			fp_d = '0;
			prev_d = '0;
		end
	end

	// Result word for the command at the head of the queue.
	always_comb begin
		logic [2:0] err;
		logic data_reply;
		err = fts_pkg::E_NONE;
		data_reply = 1'b0;
		res = '0;
		case (cmd.cls)
			fts_pkg::CMD_SHORT: err = fts_pkg::E_SHORT;
			fts_pkg::CMD_READ: begin
				if (state_q != fts_pkg::ST_READY) begin
					err = fts_pkg::E_ILLEGAL;
				end else begin
					data_reply = free;
				end
			end
			fts_pkg::CMD_WRITE: begin
				if (state_q != fts_pkg::ST_READY) begin
					err = fts_pkg::E_ILLEGAL;
				end else if (free) begin
					res.reply_kind = fts_pkg::RK_ACK;
					res.reply_length = fts_pkg::HEADER_LEN;
				end
			end
			fts_pkg::CMD_DATA: begin
				if (state_q != fts_pkg::ST_WAIT_DATA) begin
					err = fts_pkg::E_ILLEGAL;
				end else if (!pkt_ok) begin
					err = fts_pkg::E_PACKETNO;
				end else if (data_full) begin
					err = fts_pkg::E_DISKFULL;
				end else if (data_big) begin
					err = fts_pkg::E_ILLEGAL;
				end else begin
					res.move_offset = fp_q;
					res.move_count = cmd.dlen[10:0];
					res.move_is_write = 1'b1;
					res.flush_request = data_short;
					if (free) begin
						res.reply_kind = fts_pkg::RK_ACK;
						res.reply_packet = pc_q;
						res.reply_length = fts_pkg::HEADER_LEN;
					end
				end
			end
			fts_pkg::CMD_ACK: begin
				if (state_q == fts_pkg::ST_WAIT_FINAL) begin
					err = fts_pkg::E_NONE;
				end else if (state_q != fts_pkg::ST_WAIT_ACK) begin
					err = fts_pkg::E_ILLEGAL;
				end else begin
					data_reply = free;
				end
			end
			fts_pkg::CMD_BUSY: begin
				if (state_q != fts_pkg::ST_WAIT_ACK) begin
					err = fts_pkg::E_ILLEGAL;
				end else begin
					data_reply = free;
				end
			end
			fts_pkg::CMD_CANCEL: err = fts_pkg::E_NONE;
			default: err = fts_pkg::E_UNDEF;
		endcase
		if (data_reply) begin
			res.reply_kind = fts_pkg::RK_DATA;
			res.reply_packet = base_pc;
			res.reply_length = 16'(snd_cnt) + fts_pkg::HEADER_LEN;
			res.move_offset = base_fp;
			res.move_count = snd_cnt;
		end
		if (err != fts_pkg::E_NONE && free) begin
			res.reply_kind = fts_pkg::RK_ERROR;
			res.reply_packet = '0;
			res.reply_length = fts_pkg::HEADER_LEN;
			res.error_kind = err;
		end
		res.state_after = state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= fts_pkg::FILE_LIMIT_RESET;
			seg_q <= fts_pkg::SEGMENT_SIZE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				fts_pkg::CFG_FILE_LIMIT: lim_q <= cfg_data;
				fts_pkg::CFG_SEGMENT_SIZE: seg_q <= cfg_data[10:0];
				default: lim_q <= lim_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fts_pkg::ST_READY;
			pc_q <= '0;
			fp_q <= '0;
			prev_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				state_q <= state_d;
				pc_q <= pc_d;
				fp_q <= fp_d;
				prev_q <= prev_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			out_data_q <= res;
		end
	end

endmodule

### rtl/fts_checker.sv
module fts_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input fts_pkg::out_item_t out_data
);

	logic [2:0] pending_q;
	logic [1:0] last_state_q;
	logic in_acc;
	logic out_acc;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			last_state_q <= fts_pkg::ST_READY;
		end else begin
			if (in_acc && !out_acc) begin
				pending_q <= pending_q + 3'd1;
			end else if (out_acc && !in_acc) begin
				pending_q <= pending_q - 3'd1;
			end
			if (out_acc) begin
				last_state_q <= out_data.state_after;
			end
		end
	end

	// Each result word belongs to a header word that has already been taken.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result word without an accepted header word");

	// The queue and the output register hold at most three words.
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("more words in flight than the block can hold");

	// From the ready state a data reply opens a read at offset zero with packet one.
	a_read_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_state_q == fts_pkg::ST_READY && out_data.reply_kind == fts_pkg::RK_DATA
		|-> out_data.reply_packet == 32'd1 && out_data.move_offset == 24'd0)
		else $error("data reply from ready does not start the file");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result word changed");

endmodule

bind foe_file_transfer_slave_unit fts_port_checker u_fts_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);
